/* rtl/core/lcd_pkg.sv */
// lcd_pkg: shared types and fixed constants of the lidar capsule decoder
// used by lcd_front, lcd_queue, lcd_back and lidar_capsule_decoder
// no dependencies
package lcd_pkg;

   localparam int BYTE_W       = 8;
   localparam int DIST_W       = 16;
   localparam int ANGLE_W      = 20;
   localparam int START_W      = 15;
   localparam int HEADER_BYTES = 4;

   // 1/64 degree to 1/2560 degree
   localparam int ANGLE_SCALE  = 40;

   // width of the scaled angle span and of the interpolation step
   localparam int DIV_W        = 20;

   localparam logic [START_W-1:0] FULL_TURN_Q6  = 15'd23040;
   localparam logic [ANGLE_W:0]   FULL_TURN_OUT = 21'd921600;

   // one capsule ready for the back end: its start, the next start, its bank
   typedef struct packed {
      logic               bank;
      logic [START_W-1:0] start;
      logic [START_W-1:0] next;
   } job_type;

   // distance write into the sample store
   typedef struct packed {
      logic              en;
      logic              bank;
      logic [DIST_W-1:0] data;
   } mem_wr_type;

   // fill state of the job queue
   typedef struct packed {
      logic       full;
      logic       empty;
   } q_status_type;

endpackage

/* rtl/core/lcd_front.sv */
// lcd_front: byte framing, descriptor drop, start angle capture and bank control
// depends on lcd_pkg
module lcd_front #(
   parameter int SAMPLES          = 40,
   parameter int DESCRIPTOR_BYTES = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lcd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          push,
   output lcd_pkg::job_type              push_job,
   input  lcd_pkg::q_status_type         q_status,
   input  logic                          pop,
   input  logic                          pop_bank,
   output lcd_pkg::mem_wr_type           wr,
   output logic [$clog2(SAMPLES)-1:0]    wr_idx
);

   localparam int CAPSULE_BYTES = lcd_pkg::HEADER_BYTES + 2 * SAMPLES;
   localparam int POS_W         = $clog2(CAPSULE_BYTES);
   localparam int IDX_W         = $clog2(SAMPLES);
   localparam int DESC_W        = $clog2(DESCRIPTOR_BYTES + 2);

   localparam logic [POS_W-1:0] POS_ANGLE_LO = POS_W'(2);
   localparam logic [POS_W-1:0] POS_ANGLE_HI = POS_W'(3);
   localparam logic [POS_W-1:0] POS_DATA     = POS_W'(lcd_pkg::HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_END      = POS_W'(CAPSULE_BYTES - 1);

   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic [DESC_W-1:0]                desc_ff, desc_in;
   logic [lcd_pkg::START_W-1:0]      held_ff, held_in;
   logic [lcd_pkg::BYTE_W-1:0]       low_ff, low_in;
   logic                             have_ff, have_in;
   logic                             bank_ff, bank_in;
   logic [1:0]                       busy_ff, busy_in;

   logic                             accept;
   logic                             in_desc;
   logic                             is_data;
   logic                             is_high;
   logic [POS_W-1:0]                 off;
   logic [lcd_pkg::START_W-1:0]      raw_angle;
   logic [lcd_pkg::START_W-1:0]      wrap_angle;

   // byte classification
   assign in_desc = (desc_ff != '0);
   assign is_data = (pos_ff >= POS_DATA);
   assign off     = pos_ff - POS_DATA;
   assign is_high = is_data && off[0];

   // hold a byte back while the job queue is full or the bank is still being read
   assign req_stall = !in_desc &&
                      (((pos_ff == POS_ANGLE_HI) && have_ff && q_status.full) ||
                       (is_high && busy_ff[bank_ff]));
   assign accept    = req_valid && !req_stall;

   // start angle, reduced below a full turn
   assign raw_angle  = {req_data_byte[6:0], low_ff};
   assign wrap_angle = (raw_angle >= lcd_pkg::FULL_TURN_Q6) ?
                       raw_angle - lcd_pkg::FULL_TURN_Q6 : raw_angle;

   // job towards the back end
   assign push           = accept && !in_desc && (pos_ff == POS_ANGLE_HI) && have_ff;
   assign push_job.bank  = bank_ff;
   assign push_job.start = held_ff;
   assign push_job.next  = wrap_angle;

   // distance write
   assign wr.en   = accept && !in_desc && is_high;
   assign wr.bank = bank_ff;
   assign wr.data = {req_data_byte, low_ff};
   assign wr_idx  = off[IDX_W:1];

   // next state of the framing registers
   always_comb begin
      pos_in  = pos_ff;
      desc_in = desc_ff;
      held_in = held_ff;
      low_in  = low_ff;
      have_in = have_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (pop) begin
         busy_in[pop_bank] = 1'b0;
      end
      if (accept) begin
         if (in_desc) begin
            desc_in = desc_ff - DESC_W'(1);
         end else begin
            if (pos_ff == POS_ANGLE_LO) begin
               low_in = req_data_byte;
            end else if (pos_ff == POS_ANGLE_HI) begin
               held_in = wrap_angle;
               if (have_ff) begin
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = !bank_ff;
               end
            end else if (is_data && !off[0]) begin
               low_in = req_data_byte;
            end
            if (pos_ff == POS_END) begin
               pos_in  = '0;
               have_in = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         desc_ff <= DESC_W'(DESCRIPTOR_BYTES);
         held_ff <= '0;
         low_ff  <= '0;
         have_ff <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         desc_ff <= desc_in;
         held_ff <= held_in;
         low_ff  <= low_in;
         have_ff <= have_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* rtl/core/lcd_queue.sv */
// lcd_queue: two-entry job queue between the front and back ends
// depends on lcd_pkg
module lcd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lcd_pkg::job_type      push_job,
   input  logic                  pop,
   output lcd_pkg::job_type      head,
   output lcd_pkg::q_status_type status
);

   lcd_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/core/lcd_back.sv */
// lcd_back: two-bank sample store, step divider and sample emission
// depends on lcd_pkg
module lcd_back #(
   parameter int SAMPLES = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcd_pkg::job_type              head,
   input  logic                          q_empty,
   output logic                          pop,
   output logic                          busy,
   input  lcd_pkg::mem_wr_type           wr,
   input  logic [$clog2(SAMPLES)-1:0]    wr_idx,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcd_pkg::ANGLE_W-1:0]   rsp_angle,
   output logic [lcd_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_last
);

   localparam int IDX_W  = $clog2(SAMPLES);
   localparam int REM_W  = $clog2(SAMPLES);
   localparam int ADDR_W = $clog2(2 * SAMPLES);
   localparam int DIV_W  = lcd_pkg::DIV_W;
   localparam int RSH    = DIV_W + $clog2(SAMPLES);
   localparam int PROD_W = 2 * DIV_W + 1;

   localparam logic [REM_W:0]   DIVISOR  = (REM_W + 1)'(SAMPLES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   // rounded-up reciprocal of the sample count, exact for any span below 2^DIV_W
   localparam logic [DIV_W:0]   RECIP    =
      (DIV_W + 1)'(((64'd1 << RSH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_REM,
      ST_FETCH,
      ST_SEND
   } state_type;

   state_type                      state_ff;
   logic [DIV_W-1:0]               base_ff;
   logic [DIV_W-1:0]               num_ff;
   logic [DIV_W-1:0]               quot_ff;
   logic [REM_W-1:0]               rem_ff;
   logic [DIV_W-1:0]               step_ff;
   logic [REM_W-1:0]               racc_ff;
   logic [IDX_W-1:0]               idx_ff;
   logic [lcd_pkg::DIST_W-1:0]     rd_data_ff;
   logic                           rsp_valid_ff;
   logic [lcd_pkg::ANGLE_W-1:0]    rsp_angle_ff;
   logic [lcd_pkg::DIST_W-1:0]     rsp_distance_ff;
   logic                           rsp_last_ff;

   logic [lcd_pkg::DIST_W-1:0]     mem [2 * SAMPLES];

   logic [lcd_pkg::START_W-1:0]    span;
   logic [PROD_W-1:0]              prod;
   logic [DIV_W-1:0]               quot_calc;
   logic [REM_W-1:0]               rem_calc;
   logic [REM_W:0]                 racc_sum;
   logic [REM_W:0]                 racc_sub;
   logic                           carry;
   logic [lcd_pkg::ANGLE_W:0]      angle_sum;
   logic [lcd_pkg::ANGLE_W:0]      angle_wrap;
   logic                           out_free;
   logic                           is_last;
   logic [ADDR_W-1:0]              wr_addr;
   logic [ADDR_W-1:0]              rd_addr;

   // angular span to the next capsule, wrapped past a full turn
   assign span = (head.start <= head.next) ? head.next - head.start :
                 lcd_pkg::FULL_TURN_Q6 + head.next - head.start;

   // per-sample step: quotient by reciprocal multiply, then remainder
   assign prod      = PROD_W'(num_ff) * PROD_W'(RECIP);
   assign quot_calc = DIV_W'(prod >> RSH);
   assign rem_calc  = REM_W'(num_ff - DIV_W'(quot_ff * DIV_W'(SAMPLES)));

   // step accumulator: quotient plus remainder carry
   assign racc_sum = {1'b0, racc_ff} + {1'b0, rem_ff};
   assign carry    = (racc_sum >= DIVISOR);
   assign racc_sub = racc_sum - DIVISOR;

   // sample angle wrapped below a full turn
   assign angle_sum  = {1'b0, base_ff} + {1'b0, step_ff};
   assign angle_wrap = (angle_sum >= lcd_pkg::FULL_TURN_OUT) ?
                       angle_sum - lcd_pkg::FULL_TURN_OUT : angle_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = (idx_ff == LAST_IDX);
   assign pop      = (state_ff == ST_SEND) && out_free && is_last;
   assign busy     = (state_ff != ST_IDLE);

   // sample store, bank selects the half
   assign wr_addr = wr.bank ? ADDR_W'(SAMPLES) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
   assign rd_addr = head.bank ? ADDR_W'(SAMPLES) + ADDR_W'(idx_ff) : ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_SEND)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  base_ff  <= DIV_W'(head.start) * DIV_W'(lcd_pkg::ANGLE_SCALE);
                  num_ff   <= DIV_W'(span) * DIV_W'(lcd_pkg::ANGLE_SCALE);
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               quot_ff  <= quot_calc;
               state_ff <= ST_REM;
            end
            ST_REM: begin
               rem_ff   <= rem_calc;
               step_ff  <= '0;
               racc_ff  <= '0;
               idx_ff   <= '0;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_angle_ff    <= angle_wrap[lcd_pkg::ANGLE_W-1:0];
                  rsp_distance_ff <= rd_data_ff;
                  rsp_last_ff     <= is_last;
                  racc_ff         <= carry ? racc_sub[REM_W-1:0] : racc_sum[REM_W-1:0];
                  step_ff         <= step_ff + quot_ff + DIV_W'(carry);
                  idx_ff          <= idx_ff + IDX_W'(1);
                  state_ff        <= is_last ? ST_IDLE : ST_FETCH;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_angle    = rsp_angle_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* rtl/core/lidar_capsule_decoder.sv */
// lidar_capsule_decoder: top level of the lidar capsule decoder
// depends on lcd_pkg, lcd_front, lcd_queue, lcd_back
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_data_byte[7:0]
//   rsp       out        rsp_valid/rsp_stall  rsp_angle[19:0] rsp_distance[15:0] rsp_last
//
// the front takes one byte per cycle; it holds a byte back only while the job
// queue is full or the store bank it would write still holds samples not yet emitted
// each capsule passes the back end through a load step, the angle step (reciprocal
// multiply, then remainder) and, per sample, a store read and an output load
// reset is synchronous and clears framing, queue and sequencer; no clearing pass
// a stalled result holds in the output register and the sequencer waits behind it
module lidar_capsule_decoder #(
   parameter int SAMPLES          = 40,
   parameter int DESCRIPTOR_BYTES = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lcd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcd_pkg::ANGLE_W-1:0]   rsp_angle,
   output logic [lcd_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_last
);

   localparam int IDX_W = $clog2(SAMPLES);

   logic                      push;
   lcd_pkg::job_type          push_job;
   lcd_pkg::job_type          q_head;
   lcd_pkg::q_status_type     q_status;
   logic                      pop;
   logic                      back_busy;
   lcd_pkg::mem_wr_type       wr;
   logic [IDX_W-1:0]          wr_idx;

   // byte framing
   lcd_front #(
      .SAMPLES          (SAMPLES),
      .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_job      (push_job),
      .q_status      (q_status),
      .pop           (pop),
      .pop_bank      (q_head.bank),
      .wr            (wr),
      .wr_idx        (wr_idx)
   );

   // capsule jobs
   lcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (q_head),
      .status   (q_status)
   );

   // sample emission
   lcd_back #(
      .SAMPLES (SAMPLES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_empty      (q_status.empty),
      .pop          (pop),
      .busy         (back_busy),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_angle    (rsp_angle),
      .rsp_distance (rsp_distance),
      .rsp_last     (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // never overwrite the bank that is being emitted
   a_bank_apart: assert property (@(posedge clock) disable iff (reset)
      (wr.en && back_busy) |-> (wr.bank != q_head.bank))
      else $error("store write hits the bank being emitted");

   // no job is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into a full queue");

   // a capsule stays queued until its final sample is out
   a_job_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !q_status.empty)
      else $error("job released before its final sample");
`endif

endmodule
